// ===== src/box_downsample_2x2_macros.svh =====
// Assertion macros shared by the box downsampler RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BOX_DOWNSAMPLE_2X2_MACROS_SVH
`define BOX_DOWNSAMPLE_2X2_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box downsampler: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box downsampler: next-cycle check failed");

`endif

// ===== src/bds_pkg.sv =====
// Shared types and constants of the 2x2 box downsampler.
// No dependencies; every other file of the block but the assertion macros uses it.
`default_nettype none

package bds_pkg;

  localparam int PIX_W     = 8;   // input and output pixel width
  localparam int PAIR_W    = 9;   // sum of two pixels
  localparam int SUM_W     = 10;  // sum of four pixels
  localparam int CFG_W     = 12;  // configuration data width
  localparam int CFG_IDX_W = 2;   // configuration register index width

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int RST_WIDTH      = 640;
  localparam int RST_HEIGHT     = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } bds_reg_e;

  // Line-buffer operation decoded from one accepted item.
  typedef struct packed {
    logic              wr;    // even row, odd column: store the pair sum
    logic              rd;    // odd row, odd column: fetch and emit
    logic              rend;  // last output column
    logic              fin;   // last output pixel of the image
    logic [PAIR_W-1:0] pair;  // horizontal pair sum of this item
  } bds_op_t;

endpackage

`default_nettype wire

// ===== src/bds_if.sv =====
// Valid/ready stream interfaces for the input pixels and the output results.
// Depends on bds_pkg for the payload widths.
`default_nettype none

interface bds_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bds_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bds_res_if;
  logic                       valid;
  logic                       ready;
  logic [bds_pkg::PIX_W-1:0]  out_pixel;
  logic                       row_end;
  logic                       last;

  modport source (output valid, output out_pixel, output row_end, output last, input ready);
  modport sink   (input valid, input out_pixel, input row_end, input last, output ready);
endinterface

`default_nettype wire

// ===== src/box_downsample_2x2.sv =====
// 2x2 box downsampler for 8-bit grayscale raster streams. Each output pixel is
// the truncated mean of one 2x2 block; an odd last column or row is dropped,
// row_end marks the last pixel of an output row and last the final one of the
// image. One pixel is taken per clock while the input is not held off: every
// item makes at most one access to the single-port pair-sum line memory, so
// the sustained rate is one item per cycle unless the output stalls. A result
// goes from the line-buffer read into the holding stage and from there to the
// output register, where it is valid. The input is held off only while a
// result waits unaccepted on the output with a second one behind it in the
// holding stage. The line memory is never cleared; every entry is written on
// an even row before the following odd row reads it.
// Writing a dimension register restarts the frame at the next pixel.
`default_nettype none

module box_downsample_2x2 #(
  parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bds_pkg::CFG_W-1:0]     cfg_wdata_i,
  bds_pix_if.sink                       pix_i,
  bds_res_if.source                     res_o
);
  import bds_pkg::*;

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  bds_op_t           op;
  logic [IDX_W-1:0]  idx;
  logic [PAIR_W-1:0] rdata;
  logic              slot_free;
  logic              in_ready;

  assign pix_i.ready = in_ready;

  bds_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (pix_i.valid),
    .pixel_i     (pix_i.pixel),
    .slot_free_i (slot_free),
    .in_ready_o  (in_ready),
    .op_o        (op),
    .idx_o       (idx)
  );

  bds_line_buf #(
    .DEPTH (LINE_DEPTH),
    .IDX_W (IDX_W)
  ) u_line_buf (
    .clk_i   (clk_i),
    .wr_en_i (op.wr),
    .rd_en_i (op.rd),
    .addr_i  (idx),
    .wdata_i (op.pair),
    .rdata_o (rdata)
  );

  bds_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (op.rd),
    .op_i        (op),
    .rdata_i     (rdata),
    .slot_free_o (slot_free),
    .res         (res_o)
  );

endmodule

`default_nettype wire

// ===== src/bds_ctrl.sv =====
// Frame control: configuration registers, column and row counters, held left
// pixel and decode of line-buffer operations. Depends on bds_pkg.
`default_nettype none

module bds_ctrl #(
  parameter int MAX_WIDTH  = bds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bds_pkg::DEF_MAX_HEIGHT,
  parameter int IDX_W      = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bds_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic [bds_pkg::PIX_W-1:0]     pixel_i,
  input  logic                          slot_free_i,
  output logic                          in_ready_o,
  output bds_pkg::bds_op_t              op_o,
  output logic [IDX_W-1:0]              idx_o
);
  import bds_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WD = $clog2(MAX_WIDTH + 1);
  localparam int HD = $clog2(MAX_HEIGHT + 1);

  function automatic logic [WD-1:0] clamp_w(input logic [CFG_W-1:0] v);
    logic [WD-1:0] r;
    if (int'(v) < 2) begin
      r = WD'(2);
    end else if (int'(v) > MAX_WIDTH) begin
      r = WD'(MAX_WIDTH);
    end else begin
      r = WD'(v);
    end
    return r;
  endfunction

  function automatic logic [HD-1:0] clamp_h(input logic [CFG_W-1:0] v);
    logic [HD-1:0] r;
    if (int'(v) < 2) begin
      r = HD'(2);
    end else if (int'(v) > MAX_HEIGHT) begin
      r = HD'(MAX_HEIGHT);
    end else begin
      r = HD'(v);
    end
    return r;
  endfunction

  logic [WD-1:0]    width_q;
  logic [HD-1:0]    height_q;
  logic [CW-1:0]    col_q;
  logic [RW-1:0]    row_q;
  logic [PIX_W-1:0] held_q;

  logic          sel_w, sel_h;
  logic          accept;
  logic [WD-1:0] w_even;
  logic [HD-1:0] h_even;
  logic          in_blk, col_last, row_last;

  always_comb begin
    sel_w = 1'b0;
    sel_h = 1'b0;
    unique case (cfg_idx_i)
      REG_WIDTH:  sel_w = 1'b1;
      REG_HEIGHT: sel_h = 1'b1;
      default: ;
    endcase
  end

  assign in_ready_o = slot_free_i;
  assign accept     = in_valid_i & slot_free_i;

  // An odd last column or row lies outside the even-sized block area and is dropped.
  assign w_even   = {width_q[WD-1:1], 1'b0};
  assign h_even   = {height_q[HD-1:1], 1'b0};
  assign in_blk   = (WD'(col_q) < w_even) && (HD'(row_q) < h_even);
  assign col_last = (WD'(col_q) == width_q - WD'(1));
  assign row_last = (HD'(row_q) == height_q - HD'(1));

  always_comb begin
    op_o.wr   = accept & in_blk & col_q[0] & ~row_q[0];
    op_o.rd   = accept & in_blk & col_q[0] & row_q[0];
    op_o.pair = {1'b0, held_q} + {1'b0, pixel_i};
    op_o.rend = (WD'(col_q) == w_even - WD'(1));
    op_o.fin  = op_o.rend && (HD'(row_q) == h_even - HD'(1));
  end

  assign idx_o = IDX_W'(col_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= clamp_w(CFG_W'(RST_WIDTH));
      height_q <= clamp_h(CFG_W'(RST_HEIGHT));
      col_q    <= '0;
      row_q    <= '0;
      held_q   <= '0;
    end else if (cfg_we_i && (sel_w || sel_h)) begin
      // A register write restarts the frame.
      if (sel_w) begin
        width_q <= clamp_w(cfg_wdata_i);
      end
      if (sel_h) begin
        height_q <= clamp_h(cfg_wdata_i);
      end
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (in_blk && !col_q[0]) begin
        held_q <= pixel_i;
      end
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/bds_line_buf.sv =====
// Line buffer of horizontal pair sums, one synchronous single-port memory.
// Depends on bds_pkg for the entry width.
`default_nettype none

module bds_line_buf #(
  parameter int DEPTH = 1024,
  parameter int IDX_W = 10
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic                       rd_en_i,
  input  logic [IDX_W-1:0]           addr_i,
  input  logic [bds_pkg::PAIR_W-1:0] wdata_i,
  output logic [bds_pkg::PAIR_W-1:0] rdata_o
);
  import bds_pkg::*;

  logic [PAIR_W-1:0] mem [DEPTH];
  logic [PAIR_W-1:0] rdata_q;

  // Read data holds until the next read so a stalled result keeps its operand.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bds_out.sv =====
// Result path: holding stage aligned with the line-buffer read, final sum and
// output register. Depends on bds_pkg, bds_if and the assertion macros.
`default_nettype none
`include "box_downsample_2x2_macros.svh"

module bds_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  bds_pkg::bds_op_t           op_i,
  input  logic [bds_pkg::PAIR_W-1:0] rdata_i,
  output logic                       slot_free_o,
  bds_res_if.source                  res
);
  import bds_pkg::*;

  logic              b_valid_q;
  logic [PAIR_W-1:0] b_pair_q;
  logic              b_rend_q, b_fin_q;
  logic              o_valid_q;
  logic [PIX_W-1:0]  o_pix_q;
  logic              o_rend_q, o_last_q;

  logic              o_free, b_move;
  logic [SUM_W-1:0]  sum;

  assign o_free      = !o_valid_q || res.ready;
  assign b_move      = b_valid_q && o_free;
  assign slot_free_o = !b_valid_q || b_move;
  assign sum         = {1'b0, rdata_i} + {1'b0, b_pair_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (rd_en_i) begin
        b_valid_q <= 1'b1;
      end else if (b_move) begin
        b_valid_q <= 1'b0;
      end
      if (b_move) begin
        o_valid_q <= 1'b1;
      end else if (res.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      b_pair_q <= op_i.pair;
      b_rend_q <= op_i.rend;
      b_fin_q  <= op_i.fin;
    end
    if (b_move) begin
      o_pix_q  <= sum[SUM_W-1:2];
      o_rend_q <= b_rend_q;
      o_last_q <= b_fin_q;
    end
  end

  assign res.valid     = o_valid_q;
  assign res.out_pixel = o_pix_q;
  assign res.row_end   = o_rend_q;
  assign res.last      = o_last_q;

  `BDS_ASSERT_NOW(a_read_needs_slot, clk_i, rst_ni, rd_en_i, slot_free_o)
  `BDS_ASSERT_NEXT(a_read_fills_stage, clk_i, rst_ni, rd_en_i, b_valid_q)
  `BDS_ASSERT_NEXT(a_stage_not_lost, clk_i, rst_ni, b_valid_q && !o_free, b_valid_q)
  `BDS_ASSERT_NOW(a_last_ends_row, clk_i, rst_ni, o_valid_q && o_last_q, o_rend_q)

endmodule

`default_nettype wire
